/* rtl/core/assert_macros.svh */
// assertion helpers for the core rtl
// checks are compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define PFE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pfe assertion failed");
// condition must never be seen at a rising clock edge outside reset
`define PFE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pfe forbidden condition seen");
`else
`define PFE_ASSERT(lbl, clk, rstn, prop)
`define PFE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* rtl/core/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and saturation helpers for the particle Euler step core.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // fixed point format and data widths
  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int DATA_W    = 32;
  localparam int DT_W      = 16;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = 2 * DATA_W;
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int REM_W     = DATA_W - 1;
  localparam int CNT_W     = $clog2(DVD_W);

  localparam logic [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};

  // operation codes carried by each input item
  typedef enum logic [OP_W-1:0] {
    OP_INTERACT  = 2'd0,
    OP_INTEGRATE = 2'd1,
    OP_COMMIT    = 2'd2,
    OP_LOAD      = 2'd3
  } pfe_op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X  = 2'd0,
    CFG_START_Y  = 2'd1,
    CFG_START_VX = 2'd2,
    CFG_START_VY = 2'd3
  } pfe_cfg_idx_e;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_DX_DX,
    MUL_DY_DY,
    MUL_K_DX,
    MUL_K_DY,
    MUL_ACCX_DT,
    MUL_ACCY_DT,
    MUL_VELX_DT,
    MUL_VELY_DT
  } pfe_mul_sel_e;

  // register that takes the saturating accumulate of the product
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_ACC_X,
    UPD_ACC_Y,
    UPD_VEL_X,
    UPD_VEL_Y,
    UPD_NEXT_X,
    UPD_NEXT_Y
  } pfe_upd_sel_e;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ZCHK,
    ST_SQ,
    ST_SUM,
    ST_DIVI,
    ST_DIV,
    ST_KSET,
    ST_PX,
    ST_PY,
    ST_AY,
    ST_MVX,
    ST_MVY,
    ST_VY,
    ST_NX,
    ST_NY,
    ST_NYU,
    ST_APPLY,
    ST_DONE
  } pfe_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic         capture;
    logic         diff_ld;
    logic         zero_set;
    logic         mul_en;
    pfe_mul_sel_e mul_sel;
    logic         sum_ld;
    logic         sum_add;
    logic         div_init;
    logic         div_step;
    logic         k_ld;
    pfe_upd_sel_e upd_sel;
    logic         acc_clr;
    logic         commit;
    logic         load;
    logic         out_ld;
  } pfe_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_dist;
    logic out_free;
  } pfe_stat_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } pfe_sat_t;

  // sign extend a 32 bit value to the wide working width
  function automatic logic signed [PROD_W-1:0] sext_f(input logic [DATA_W-1:0] v);
    sext_f = {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // clamp a wide signed value to 32 bits and flag a clamp
  function automatic pfe_sat_t sat_f(input logic signed [PROD_W-1:0] v);
    pfe_sat_t r;
    logic     fits;
    fits = (&v[PROD_W-1:DATA_W-1]) | ~(|v[PROD_W-1:DATA_W-1]);
    r.sat = ~fits;
    if (fits) begin
      r.val = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      r.val = MIN32;
    end else begin
      r.val = MAX32;
    end
    sat_f = r;
  endfunction

endpackage

/* rtl/core/pfe_in_if.sv */
// ----------------------------------------------------------------------------
// pfe_in_if
// Input item channel: operation and its operands with valid/ready transfer.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] other_x;
  logic signed [31:0] other_y;
  logic signed [31:0] other_mass;
  logic [15:0]        step_time;

  modport source (
    output valid, operation, other_x, other_y, other_mass, step_time,
    input  ready
  );
  modport sink (
    input  valid, operation, other_x, other_y, other_mass, step_time,
    output ready
  );
endinterface

/* rtl/core/pfe_out_if.sv */
// ----------------------------------------------------------------------------
// pfe_out_if
// Result channel: particle state after each item with valid/ready transfer.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_vx;
  logic signed [31:0] out_vy;
  logic               zero_distance;
  logic               saturated;

  modport source (
    output valid, out_x, out_y, out_vx, out_vy, zero_distance, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_vx, out_vy, zero_distance, saturated,
    output ready
  );
endinterface

/* rtl/core/pfe_datapath.sv */
// ----------------------------------------------------------------------------
// pfe_datapath
// Particle state, shared multiplier, restoring divider, saturating updates
// and the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module pfe_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pfe_pkg::pfe_cmd_t                    cmd_i,
  output pfe_pkg::pfe_stat_t                   stat_o,
  input  logic [pfe_pkg::DATA_W-1:0]           other_x_i,
  input  logic [pfe_pkg::DATA_W-1:0]           other_y_i,
  input  logic [pfe_pkg::DATA_W-1:0]           other_mass_i,
  input  logic [pfe_pkg::DT_W-1:0]             step_time_i,
  input  logic                                 cfg_we_i,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pfe_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [pfe_pkg::DATA_W-1:0]           out_x_o,
  output logic [pfe_pkg::DATA_W-1:0]           out_y_o,
  output logic [pfe_pkg::DATA_W-1:0]           out_vx_o,
  output logic [pfe_pkg::DATA_W-1:0]           out_vy_o,
  output logic                                 out_zero_o,
  output logic                                 out_sat_o
);
  import pfe_pkg::*;

  // configuration registers
  logic [DATA_W-1:0] start_x_q, start_y_q, start_vx_q, start_vy_q;
  // particle state
  logic [DATA_W-1:0] pos_x_q, pos_y_q, next_x_q, next_y_q;
  logic [DATA_W-1:0] vel_x_q, vel_y_q, acc_x_q, acc_y_q;
  // per item flags and result valid
  logic              sat_q, zero_q, out_valid_q;
  // captured operands and working registers
  logic [DATA_W-1:0] ox_q, oy_q, m_q;
  logic [DT_W-1:0]   dt_q;
  logic [DATA_W-1:0] dx_q, dy_q, k_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  s_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [REM_W-1:0]  rem_q, dsr_q;
  // result payload
  logic [DATA_W-1:0] res_x_q, res_y_q, res_vx_q, res_vy_q;
  logic              res_zero_q, res_sat_q;

  // combinational terms
  pfe_sat_t                 dx_r, dy_r, term_r, sum_r;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] term_w, add_w;
  logic [DATA_W-1:0]        tgt;
  logic                     upd_frac, upd_sat;
  logic                     d2_hi;
  logic [REM_W-1:0]         d2_raw, d2;
  logic [DATA_W-1:0]        mag;
  logic [REM_W:0]           trial, trial_sub;
  logic                     trial_ge;
  logic                     k_ovf;
  logic [DATA_W-1:0]        k_val;

  // position differences
  always_comb begin
    dx_r = sat_f(sext_f(pos_x_q) - sext_f(ox_q));
    dy_r = sat_f(sext_f(pos_y_q) - sext_f(oy_q));
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_DX_DX: begin
        mul_a = {dx_q[DATA_W-1], dx_q};
        mul_b = {dx_q[DATA_W-1], dx_q};
      end
      MUL_DY_DY: begin
        mul_a = {dy_q[DATA_W-1], dy_q};
        mul_b = {dy_q[DATA_W-1], dy_q};
      end
      MUL_K_DX: begin
        mul_a = {k_q[DATA_W-1], k_q};
        mul_b = {dx_q[DATA_W-1], dx_q};
      end
      MUL_K_DY: begin
        mul_a = {k_q[DATA_W-1], k_q};
        mul_b = {dy_q[DATA_W-1], dy_q};
      end
      MUL_ACCX_DT: begin
        mul_a = {acc_x_q[DATA_W-1], acc_x_q};
        mul_b = {{(MUL_W-DT_W){1'b0}}, dt_q};
      end
      MUL_ACCY_DT: begin
        mul_a = {acc_y_q[DATA_W-1], acc_y_q};
        mul_b = {{(MUL_W-DT_W){1'b0}}, dt_q};
      end
      MUL_VELX_DT: begin
        mul_a = {vel_x_q[DATA_W-1], vel_x_q};
        mul_b = {{(MUL_W-DT_W){1'b0}}, dt_q};
      end
      MUL_VELY_DT: begin
        mul_a = {vel_y_q[DATA_W-1], vel_y_q};
        mul_b = {{(MUL_W-DT_W){1'b0}}, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating accumulate of the shifted product into the selected register
  always_comb begin
    tgt      = '0;
    upd_frac = 1'b0;
    unique case (cmd_i.upd_sel)
      UPD_ACC_X:  begin tgt = acc_x_q;  upd_frac = 1'b1; end
      UPD_ACC_Y:  begin tgt = acc_y_q;  upd_frac = 1'b1; end
      UPD_VEL_X:  tgt = vel_x_q;
      UPD_VEL_Y:  tgt = vel_y_q;
      UPD_NEXT_X: tgt = next_x_q;
      UPD_NEXT_Y: tgt = next_y_q;
      default:    tgt = '0;
    endcase
    term_w  = upd_frac ? (prod_q >>> FRAC_BITS) : (prod_q >>> DT_BITS);
    term_r  = sat_f(term_w);
    add_w   = sext_f(tgt) + sext_f(term_r.val);
    sum_r   = sat_f(add_w);
    upd_sat = (cmd_i.upd_sel != UPD_NONE) && (term_r.sat || sum_r.sat);
  end

  // squared distance scaled back, clamped, at least one
  always_comb begin
    d2_hi  = |s_q[SUM_W-1:FRAC_BITS+REM_W];
    d2_raw = s_q[FRAC_BITS+REM_W-1:FRAC_BITS];
    if (d2_hi) begin
      d2 = MAX32[REM_W-1:0];
    end else if (d2_raw == '0) begin
      d2 = REM_W'(1);
    end else begin
      d2 = d2_raw;
    end
    mag = m_q[DATA_W-1] ? (~m_q + DATA_W'(1)) : m_q;
  end

  // one restoring division step
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    trial_sub = trial - {1'b0, dsr_q};
    trial_ge  = (trial >= {1'b0, dsr_q});
  end

  // signed pull factor from the quotient
  always_comb begin
    if (m_q[DATA_W-1]) begin
      k_ovf = (|dvd_q[DVD_W-1:DATA_W]) || (dvd_q[DATA_W-1] && (|dvd_q[DATA_W-2:0]));
      k_val = k_ovf ? MIN32 : (~dvd_q[DATA_W-1:0] + DATA_W'(1));
    end else begin
      k_ovf = |dvd_q[DVD_W-1:DATA_W-1];
      k_val = k_ovf ? MAX32 : dvd_q[DATA_W-1:0];
    end
  end

  // state, configuration and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_vx_q  <= '0;
      start_vy_q  <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      next_x_q    <= '0;
      next_y_q    <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      sat_q       <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (pfe_cfg_idx_e'(cfg_idx_i))
          CFG_START_X:  start_x_q  <= cfg_data_i;
          CFG_START_Y:  start_y_q  <= cfg_data_i;
          CFG_START_VX: start_vx_q <= cfg_data_i;
          CFG_START_VY: start_vy_q <= cfg_data_i;
          default:      start_x_q  <= start_x_q;
        endcase
      end
      // load and commit
      if (cmd_i.load) begin
        pos_x_q  <= start_x_q;
        pos_y_q  <= start_y_q;
        next_x_q <= start_x_q;
        next_y_q <= start_y_q;
        vel_x_q  <= start_vx_q;
        vel_y_q  <= start_vy_q;
        acc_x_q  <= '0;
        acc_y_q  <= '0;
      end
      if (cmd_i.commit) begin
        pos_x_q <= next_x_q;
        pos_y_q <= next_y_q;
      end
      // accumulate updates
      case (cmd_i.upd_sel)
        UPD_ACC_X:  acc_x_q  <= sum_r.val;
        UPD_ACC_Y:  acc_y_q  <= sum_r.val;
        UPD_VEL_X:  vel_x_q  <= sum_r.val;
        UPD_VEL_Y:  vel_y_q  <= sum_r.val;
        UPD_NEXT_X: next_x_q <= sum_r.val;
        UPD_NEXT_Y: next_y_q <= sum_r.val;
        default: ;
      endcase
      if (cmd_i.acc_clr) begin
        acc_x_q <= '0;
        acc_y_q <= '0;
      end
      // per item flags
      if (cmd_i.capture) begin
        sat_q  <= 1'b0;
        zero_q <= 1'b0;
      end else begin
        if ((cmd_i.diff_ld && (dx_r.sat || dy_r.sat)) || (cmd_i.div_init && d2_hi) ||
            (cmd_i.k_ld && k_ovf) || upd_sat) begin
          sat_q <= 1'b1;
        end
        if (cmd_i.zero_set) begin
          zero_q <= 1'b1;
        end
      end
      // result valid until transfer
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operands, working registers and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ox_q <= other_x_i;
      oy_q <= other_y_i;
      m_q  <= other_mass_i;
      dt_q <= step_time_i;
    end
    if (cmd_i.diff_ld) begin
      dx_q <= dx_r.val;
      dy_q <= dy_r.val;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.sum_ld) begin
      s_q <= prod_q[SUM_W-1:0];
    end else if (cmd_i.sum_add) begin
      s_q <= s_q + prod_q[SUM_W-1:0];
    end
    // divider
    if (cmd_i.div_init) begin
      dvd_q <= {mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dsr_q <= d2;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], trial_ge};
    end
    if (cmd_i.k_ld) begin
      k_q <= k_val;
    end
    if (cmd_i.out_ld) begin
      res_x_q    <= pos_x_q;
      res_y_q    <= pos_y_q;
      res_vx_q   <= vel_x_q;
      res_vy_q   <= vel_y_q;
      res_zero_q <= zero_q;
      res_sat_q  <= sat_q;
    end
  end

  // status and outputs
  assign stat_o.zero_dist = (dx_q == '0) && (dy_q == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_x_o          = res_x_q;
  assign out_y_o          = res_y_q;
  assign out_vx_o         = res_vx_q;
  assign out_vy_o         = res_vy_q;
  assign out_zero_o       = res_zero_q;
  assign out_sat_o        = res_sat_q;

endmodule

/* rtl/core/pfe_ctrl.sv */
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: walks interact and integrate through the multiplier, divider and
// update steps, applies commit or load and hands the result to the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfe_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [pfe_pkg::OP_W-1:0]    in_op_i,
  output logic                        in_ready_o,
  input  pfe_pkg::pfe_stat_t          stat_i,
  output pfe_pkg::pfe_cmd_t           cmd_o
);
  import pfe_pkg::*;

  pfe_state_e       state_q, state_d;
  pfe_op_e          op_q, op_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_INTERACT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          op_d          = pfe_op_e'(in_op_i);
          unique case (pfe_op_e'(in_op_i))
            OP_INTERACT:  state_d = ST_DIFF;
            OP_INTEGRATE: state_d = ST_MVX;
            OP_COMMIT:    state_d = ST_APPLY;
            OP_LOAD:      state_d = ST_APPLY;
            default:      state_d = ST_APPLY;
          endcase
        end
      end
      // interact: differences, squares, divide, pull
      ST_DIFF: begin
        cmd_o.diff_ld = 1'b1;
        state_d       = ST_ZCHK;
      end
      ST_ZCHK: begin
        if (stat_i.zero_dist) begin
          cmd_o.zero_set = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_DX_DX;
          state_d       = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DY_DY;
        cmd_o.sum_ld  = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_add = 1'b1;
        state_d       = ST_DIVI;
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          state_d = ST_KSET;
        end
      end
      ST_KSET: begin
        cmd_o.k_ld = 1'b1;
        state_d    = ST_PX;
      end
      ST_PX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_K_DX;
        state_d       = ST_PY;
      end
      ST_PY: begin
        cmd_o.upd_sel = UPD_ACC_X;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_K_DY;
        state_d       = ST_AY;
      end
      ST_AY: begin
        cmd_o.upd_sel = UPD_ACC_Y;
        state_d       = ST_DONE;
      end
      // integrate: velocity first, then next position from the new velocity
      ST_MVX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ACCX_DT;
        state_d       = ST_MVY;
      end
      ST_MVY: begin
        cmd_o.upd_sel = UPD_VEL_X;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ACCY_DT;
        state_d       = ST_VY;
      end
      ST_VY: begin
        cmd_o.upd_sel = UPD_VEL_Y;
        state_d       = ST_NX;
      end
      ST_NX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VELX_DT;
        state_d       = ST_NY;
      end
      ST_NY: begin
        cmd_o.upd_sel = UPD_NEXT_X;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VELY_DT;
        state_d       = ST_NYU;
      end
      ST_NYU: begin
        cmd_o.upd_sel = UPD_NEXT_Y;
        cmd_o.acc_clr = 1'b1;
        state_d       = ST_DONE;
      end
      // commit or load
      ST_APPLY: begin
        cmd_o.commit = (op_q == OP_COMMIT);
        cmd_o.load   = (op_q == OP_LOAD);
        state_d      = ST_DONE;
      end
      // wait for room in the result register
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // checks
  `PFE_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
  `PFE_ASSERT(a_div_count_range, clk_i, rst_ni, (state_q == ST_DIV) |-> (cnt_q <= CNT_W'(DVD_W - 1)))
  `PFE_ASSERT(a_result_load_free, clk_i, rst_ni, cmd_o.out_ld |-> stat_i.out_free)
  `PFE_ASSERT_NEVER(a_no_accept_on_result, clk_i, rst_ni, in_ready_o && cmd_o.out_ld)

endmodule

/* rtl/core/particle_force_euler_step_core.sv */
// interact items pass through the bit-serial divider, which is skipped when the positions coincide
// throughput: one item at a time, next item taken the cycle after its result is registered
// reset: asynchronous active low, clears position, velocity, accumulator and start registers
// ----------------------------------------------------------------------------
// particle_force_euler_step_core
// One 2D particle in signed fixed point: gravity-like interaction, symplectic
// Euler integration, position commit and load from configuration.
// ----------------------------------------------------------------------------
module particle_force_euler_step_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pfe_in_if.sink                              in_i,
  pfe_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pfe_pkg::DATA_W-1:0]          cfg_data_i
);
  import pfe_pkg::*;

  pfe_cmd_t  cmd;
  pfe_stat_t stat;
  logic      in_ready;

  // controller
  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // datapath
  pfe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .other_x_i    (in_i.other_x),
    .other_y_i    (in_i.other_y),
    .other_mass_i (in_i.other_mass),
    .step_time_i  (in_i.step_time),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y),
    .out_vx_o     (out_o.out_vx),
    .out_vy_o     (out_o.out_vy),
    .out_zero_o   (out_o.zero_distance),
    .out_sat_o    (out_o.saturated)
  );

endmodule

/* tb/sv/particle_force_euler_step_core_tb.sv */
// ----------------------------------------------------------------------------
// particle_force_euler_step_core_tb
// Drives operation items into the particle core and checks every result
// against a fixed-point predictor of the particle state or a directed table.
// The table covers reset, extremes, coincident and sub-resolution distances;
// random sequences of all four operations follow under several start settings.
// ----------------------------------------------------------------------------
module particle_force_euler_step_core_tb;
  import pfe_pkg::*;

  localparam int     TAIL_CYCLES  = 80;
  localparam int     NUM_PHASES   = 6;
  localparam int     PHASE_ITEMS  = 200;
  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;

  typedef struct {
    pfe_op_e            op;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] mass;
    logic [15:0]        dt;
  } step_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               zero;
    logic               sat;
  } step_res_t;

  typedef struct {
    step_item_t it;
    bit         typed;
    step_res_t  want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();

  step_res_t particle_q[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  // predictor copy of the particle and the start registers
  longint held_x = 0, held_y = 0, ahead_x = 0, ahead_y = 0;
  longint speed_x = 0, speed_y = 0, pull_x = 0, pull_y = 0;
  longint load_x = 0, load_y = 0, load_vx = 0, load_vy = 0;
  bit     clipped;

  particle_force_euler_step_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("** particle_force_euler_step_core: FAILED **");
    $finish;
  end

  // clamp to signed 32 bits, noting any clamp
  function automatic longint saturate_word(input longint v);
    if (v > WORD_MAX) begin
      clipped = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clipped = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // gravity-like pull along one axis, floored
  function automatic longint force_term(input longint k, input longint d);
    return saturate_word((k * d) >>> FRAC_BITS);
  endfunction

  // advance the predicted particle by one item
  function automatic step_res_t particle_advance(input step_item_t it);
    step_res_t   r;
    longint      dx, dy, m, k, dt;
    logic [63:0] sumsq, d2, mag, quo;
    bit          coincident;
    clipped    = 1'b0;
    coincident = 1'b0;
    case (it.op)
      OP_INTERACT: begin
        dx = saturate_word(held_x - longint'(it.ox));
        dy = saturate_word(held_y - longint'(it.oy));
        if (dx == 0 && dy == 0) begin
          coincident = 1'b1;
        end else begin
          sumsq = dx * dx + dy * dy;
          d2    = sumsq >> FRAC_BITS;
          if (d2 > 64'h7FFF_FFFF) begin
            clipped = 1'b1;
            d2      = 64'h7FFF_FFFF;
          end
          // distance below resolution still divides by one
          if (d2 == 0) begin
            d2 = 1;
          end
          m   = longint'(it.mass);
          mag = (m < 0) ? -m : m;
          quo = (mag << FRAC_BITS) / d2;
          if (quo > 64'h1_0000_0000) begin
            quo = 64'h1_0000_0000;
          end
          k = (m < 0) ? -longint'(quo) : longint'(quo);
          k = saturate_word(k);
          pull_x = saturate_word(pull_x + force_term(k, dx));
          pull_y = saturate_word(pull_y + force_term(k, dy));
        end
      end
      OP_INTEGRATE: begin
        dt      = longint'(it.dt);
        speed_x = saturate_word(speed_x + ((pull_x * dt) >>> DT_BITS));
        speed_y = saturate_word(speed_y + ((pull_y * dt) >>> DT_BITS));
        ahead_x = saturate_word(ahead_x + ((speed_x * dt) >>> DT_BITS));
        ahead_y = saturate_word(ahead_y + ((speed_y * dt) >>> DT_BITS));
        pull_x  = 0;
        pull_y  = 0;
      end
      OP_COMMIT: begin
        held_x = ahead_x;
        held_y = ahead_y;
      end
      default: begin
        held_x  = load_x;
        held_y  = load_y;
        ahead_x = load_x;
        ahead_y = load_y;
        speed_x = load_vx;
        speed_y = load_vy;
        pull_x  = 0;
        pull_y  = 0;
      end
    endcase
    r.x    = 32'(held_x);
    r.y    = 32'(held_y);
    r.vx   = 32'(speed_x);
    r.vy   = 32'(speed_y);
    r.zero = coincident;
    r.sat  = clipped;
    return r;
  endfunction

  // stimulus value pickers
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return MAX32;
      1:       return MIN32;
      2:       return '0;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_mass();
    case ($urandom_range(0, 9))
      0:       return MAX32;
      1:       return MIN32;
      2:       return '0;
      3:       return $urandom;
      default: return $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h1000));
    endcase
  endfunction

  function automatic logic signed [31:0] near_offset();
    return $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
  endfunction

  // well-formed item; interact partners sit mostly near the particle
  function automatic step_item_t make_item(input pfe_op_e op);
    step_item_t it;
    it.op   = op;
    it.ox   = $urandom;
    it.oy   = $urandom;
    it.mass = $urandom;
    it.dt   = 16'($urandom);
    if (op == OP_INTERACT) begin
      it.mass = pick_mass();
      if ($urandom_range(0, 9) == 0) begin
        it.ox = 32'(held_x);
        it.oy = 32'(held_y);
      end else if ($urandom_range(0, 5) != 0) begin
        it.ox = 32'(held_x) - near_offset();
        it.oy = 32'(held_y) - near_offset();
      end
    end else if (op == OP_INTEGRATE) begin
      it.dt = pick_step();
    end
    return it;
  endfunction

  function automatic step_item_t item_of(input pfe_op_e op, input logic signed [31:0] ox,
                                         input logic signed [31:0] oy,
                                         input logic signed [31:0] mass,
                                         input logic [15:0] dt);
    step_item_t it;
    it.op   = op;
    it.ox   = ox;
    it.oy   = oy;
    it.mass = mass;
    it.dt   = dt;
    return it;
  endfunction

  function automatic stim_row_t plain_row(input step_item_t it);
    stim_row_t row;
    row.it    = it;
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t known_row(input step_item_t it,
                                          input logic signed [31:0] x, y, vx, vy,
                                          input logic zero, sat);
    stim_row_t row;
    row.it        = it;
    row.typed     = 1'b1;
    row.want.x    = x;
    row.want.y    = y;
    row.want.vx   = vx;
    row.want.vy   = vy;
    row.want.zero = zero;
    row.want.sat  = sat;
    return row;
  endfunction

  task automatic note_error(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      note_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // register write, one per cycle; the predictor copy follows
  task automatic write_reg(input pfe_cfg_idx_e idx, input logic signed [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_START_X:  load_x  = longint'(value);
      CFG_START_Y:  load_y  = longint'(value);
      CFG_START_VX: load_vx = longint'(value);
      default:      load_vy = longint'(value);
    endcase
  endtask

  task automatic write_start(input logic signed [31:0] sx, sy, svx, svy);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_VX, svx);
    write_reg(CFG_START_VY, svy);
    cfg_we_i <= 1'b0;
  endtask

  // offer one item, wait for its transfer, then queue its expected result
  task automatic send_item(input stim_row_t row);
    step_res_t pred;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= row.it.op;
    in_ch.other_x    <= row.it.ox;
    in_ch.other_y    <= row.it.oy;
    in_ch.other_mass <= row.it.mass;
    in_ch.step_time  <= row.it.dt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = particle_advance(row.it);
    particle_q.push_back(row.typed ? row.want : pred);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every queued result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (particle_q.size() == 0);
    @(posedge clk_i);
  endtask

  // receiver side: random stall bursts and stall-free stretches
  initial begin : result_ready
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 63) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result check on every output transfer
  always @(posedge clk_i) begin : result_check
    step_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (particle_q.size() == 0) begin
        note_error("result with nothing expected");
      end else begin
        want = particle_q.pop_front();
        check_field("out_x", out_ch.out_x, want.x);
        check_field("out_y", out_ch.out_y, want.y);
        check_field("out_vx", out_ch.out_vx, want.vx);
        check_field("out_vy", out_ch.out_vy, want.vy);
        check_field("zero_distance", out_ch.zero_distance, want.zero);
        check_field("saturated", out_ch.saturated, want.sat);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t rows[$];
    int        sent;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_START_X;
    cfg_data_i       <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_COMMIT;
    in_ch.other_x    <= '0;
    in_ch.other_y    <= '0;
    in_ch.other_mass <= '0;
    in_ch.step_time  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset state, extremes, coincident and tiny distances
    write_start(MAX32, MIN32, MAX32, MIN32);
    // unused fields all ones after reset
    rows.push_back(known_row(item_of(OP_COMMIT, '1, '1, '1, '1), 0, 0, 0, 0, 0, 0));
    rows.push_back(known_row(item_of(OP_INTERACT, 0, 0, 32'sh1_0000, '1),
                             0, 0, 0, 0, 1'b1, 0));
    rows.push_back(known_row(item_of(OP_INTEGRATE, '1, '1, '1, 16'hFFFF), 0, 0, 0, 0, 0, 0));
    rows.push_back(known_row(item_of(OP_LOAD, '1, '1, '1, '1),
                             MAX32, MIN32, MAX32, MIN32, 0, 0));
    // widest distance, d2 clamps
    rows.push_back(plain_row(item_of(OP_INTERACT, MIN32, MAX32, MAX32, '0)));
    rows.push_back(plain_row(item_of(OP_INTEGRATE, '0, '0, '0, 16'hFFFF)));
    rows.push_back(plain_row(item_of(OP_COMMIT, '0, '0, '0, '0)));
    rows.push_back(known_row(item_of(OP_LOAD, '0, '0, '0, '0),
                             MAX32, MIN32, MAX32, MIN32, 0, 0));
    rows.push_back(known_row(item_of(OP_INTERACT, MAX32, MIN32, MIN32, '0),
                             MAX32, MIN32, MAX32, MIN32, 1'b1, 0));
    // one lsb apart, d2 rounds to zero
    rows.push_back(plain_row(item_of(OP_INTERACT, 32'sh7FFF_FFFE, MIN32, 32'sh1_0000, '0)));
    rows.push_back(plain_row(item_of(OP_INTERACT, 0, 0, 0, '0)));
    rows.push_back(plain_row(item_of(OP_INTEGRATE, '1, '1, '1, 16'h0000)));
    rows.push_back(plain_row(item_of(OP_INTEGRATE, '0, '0, '0, 16'hFFFF)));
    rows.push_back(plain_row(item_of(OP_COMMIT, '1, '1, '1, '1)));
    rows.push_back(plain_row(item_of(OP_INTERACT, 32'sh4000_0000, -32'sh4000_0000, MIN32, '0)));
    rows.push_back(plain_row(item_of(OP_INTEGRATE, '0, '0, '0, 16'h8000)));
    rows.push_back(plain_row(item_of(OP_COMMIT, '0, '0, '0, '0)));
    rows.push_back(known_row(item_of(OP_LOAD, '0, '0, '0, '0),
                             MAX32, MIN32, MAX32, MIN32, 0, 0));
    // next position runs off both ends
    rows.push_back(known_row(item_of(OP_INTEGRATE, '0, '0, '0, 16'hFFFF),
                             MAX32, MIN32, MAX32, MIN32, 0, 1'b1));
    rows.push_back(known_row(item_of(OP_COMMIT, '0, '0, '0, '0),
                             MAX32, MIN32, MAX32, MIN32, 0, 0));
    // unit distance, most negative mass
    rows.push_back(plain_row(item_of(OP_INTERACT, 32'sh7FFE_FFFF, MIN32, MIN32, '0)));
    rows.push_back(plain_row(item_of(OP_INTEGRATE, '0, '0, '0, 16'h0001)));
    rows.push_back(plain_row(item_of(OP_COMMIT, '0, '0, '0, '0)));
    rows.push_back(plain_row(item_of(OP_LOAD, $urandom, $urandom, $urandom, 16'($urandom))));
    foreach (rows[i]) begin
      send_item(rows[i]);
    end
    drain_results();

    // random phases, each under its own start setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1:       write_start(MAX32, MAX32, MAX32, MAX32);
        2:       write_start(MIN32, MIN32, MIN32, MIN32);
        3:       write_start('0, '0, MAX32, MIN32);
        default: write_start(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      if (phase == NUM_PHASES - 1) begin
        calm = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any operation, any fields
          send_item(plain_row(item_of(pfe_op_e'($urandom_range(OP_INTERACT, OP_LOAD)),
                                      $urandom, $urandom, $urandom, 16'($urandom))));
          sent++;
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(plain_row(make_item(OP_LOAD)));
            sent++;
          end
          repeat ($urandom_range(1, 4)) begin
            send_item(plain_row(make_item(OP_INTERACT)));
            sent++;
          end
          send_item(plain_row(make_item(OP_INTEGRATE)));
          sent++;
          if ($urandom_range(0, 3) != 0) begin
            send_item(plain_row(make_item(OP_COMMIT)));
            sent++;
          end
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && particle_q.size() == 0) begin
      $display("** particle_force_euler_step_core: PASSED **");
    end else begin
      $display("** particle_force_euler_step_core: FAILED **");
    end
    $finish;
  end

endmodule

/* particle_force_euler_step_core.f */
+incdir+rtl/core
rtl/core/pfe_pkg.sv
rtl/core/pfe_in_if.sv
rtl/core/pfe_out_if.sv
rtl/core/pfe_datapath.sv
rtl/core/pfe_ctrl.sv
rtl/core/particle_force_euler_step_core.sv
tb/sv/particle_force_euler_step_core_tb.sv
